// ===== rtl/firmware_lifecycle_state_machine_core_defines.svh =====
// assertion macros used by the checker file
`ifndef FIRMWARE_LIFECYCLE_STATE_MACHINE_CORE_DEFINES_SVH
`define FIRMWARE_LIFECYCLE_STATE_MACHINE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FLSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lifecycle check failed");

// next-cycle implication, disabled in reset
`define FLSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lifecycle check failed");

`endif

// ===== rtl/flsm_pkg.sv =====
// types and codes for the firmware lifecycle state machine
package flsm_pkg;

  // state codes; the top code also marks "no request pending"
  typedef enum logic [2:0] {
    ST_S0         = 3'd0,
    ST_IDLE       = 3'd1,
    ST_CONFIGURED = 3'd2,
    ST_OPREADY    = 3'd3,
    ST_STOPPING   = 3'd4,
    ST_ERROR      = 3'd5,
    ST_FATAL      = 3'd6,
    ST_NONE       = 3'd7
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_CONFIGURE = 3'd1,
    CMD_START     = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_IDLE      = 3'd4,
    CMD_RECOVER   = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_UNKNOWN   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_ENTER_CFG = 3'd1,
    ACT_ENTER_OP  = 3'd2,
    ACT_EXIT_OP   = 3'd3,
    ACT_EXIT_ERR  = 3'd4
  } act_t;

  localparam logic [1:0] FAULT_ERROR = 2'd1;
  localparam logic [1:0] FAULT_FATAL = 2'd2;

endpackage

// ===== rtl/firmware_lifecycle_state_machine_core.sv =====
// firmware lifecycle state machine: input register, transition logic, result register
// Each accepted word is one pass of the control loop and yields exactly one result word.
// A word is captured in the input register. The transition and state-action logic works on
// the registered word and writes both the held state and the result register when the
// word advances, which waits while a held result is not taken. One word is taken every
// cycle while the output side keeps up; a held result stalls the input once the input
// register is also full. The rate is set by the transition logic feeding the state
// registers back to itself. Once FATAL is reached every later word repeats FATAL.
module firmware_lifecycle_state_machine_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       func,
  input  logic [1:0]       fault_request,
  input  logic [3:0]       action_status,
  input  logic [3:0]       init_status,
  output logic             out_valid,
  input  logic             out_ready,
  output flsm_pkg::state_t state_now,
  output logic [3:0]       status_now,
  output flsm_pkg::act_t   action_fired,
  output logic             clear_diag_pulse,
  output logic             state_changed
);
  import flsm_pkg::*;

  // input register
  logic       s1_valid;
  cmd_t       s1_func;
  logic [1:0] s1_fault;
  logic [3:0] s1_act;
  logic [3:0] s1_init;
  logic       advance;

  // held state
  state_t     current_state;
  state_t     pending_request;
  logic [3:0] status_reg;
  logic       recover_flag;

  // pass logic
  state_t     req;
  state_t     nxt;
  logic [3:0] trans;
  act_t       action;
  logic       pulse;
  logic       changed;
  state_t     current_state_next;
  state_t     pending_request_next;
  logic [3:0] status_reg_next;
  logic       recover_flag_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_func  <= cmd_t'(func);
      s1_fault <= fault_request;
      s1_act   <= action_status;
      s1_init  <= init_status;
    end
  end

  // request mapping and transitions
  always_comb begin
    req    = pending_request;
    pulse  = 1'b0;
    trans  = 4'd0;
    action = ACT_NONE;
    nxt    = current_state;
    case (s1_func)
      CMD_CONFIGURE:         req = ST_CONFIGURED;
      CMD_START:             req = ST_OPREADY;
      CMD_STOP:              req = ST_STOPPING;
      CMD_IDLE, CMD_RECOVER: req = ST_IDLE;
      CMD_CLEAR:             pulse = 1'b1;
      default:               ;
    endcase
    if (s1_fault == FAULT_ERROR) begin
      req = ST_ERROR;
    end else if (s1_fault == FAULT_FATAL) begin
      req = ST_FATAL;
    end

    if (current_state == ST_FATAL) begin
      pulse = 1'b0;
    end else if (req == ST_ERROR || req == ST_FATAL) begin
      trans = status_reg;
      nxt   = req;
    end else begin
      unique case (current_state)
        ST_S0: begin
          if (req == ST_IDLE) nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (req == ST_CONFIGURED) begin
            action = ACT_ENTER_CFG;
            trans  = s1_act;
            nxt    = ST_CONFIGURED;
          end
        end
        ST_CONFIGURED: begin
          if (req == ST_IDLE) begin
            nxt = ST_IDLE;
          end else if (req == ST_CONFIGURED) begin
            action = ACT_ENTER_CFG;
            trans  = s1_act;
            nxt    = ST_CONFIGURED;
          end else if (req == ST_OPREADY) begin
            action = ACT_ENTER_OP;
            trans  = s1_act;
            nxt    = ST_OPREADY;
          end
        end
        ST_OPREADY: begin
          if (req == ST_STOPPING) begin
            action = ACT_EXIT_OP;
            trans  = s1_act;
            nxt    = ST_STOPPING;
          end
        end
        ST_STOPPING: begin
          nxt = ST_CONFIGURED;
          if (req == ST_IDLE) begin
            action = ACT_EXIT_ERR;
            nxt    = ST_IDLE;
          end
        end
        ST_ERROR: begin
          if (req == ST_IDLE) begin
            action = ACT_EXIT_ERR;
            nxt    = ST_IDLE;
          end
        end
        default: nxt = ST_S0;
      endcase
    end

    // a failing action diverts to error
    if (trans != 4'd0 && nxt != ST_FATAL) nxt = ST_ERROR;
    changed = (nxt != current_state);
  end

  // state action: status, follow-up request and auto-recovery
  always_comb begin
    current_state_next   = nxt;
    status_reg_next      = changed ? trans : status_reg;
    pending_request_next = pending_request;
    recover_flag_next    = recover_flag;
    if (nxt != ST_FATAL) begin
      pending_request_next = ST_NONE;
      if (nxt == ST_S0) begin
        status_reg_next      = s1_init;
        pending_request_next = (s1_init != 4'd0) ? ST_FATAL : ST_IDLE;
      end
      if (nxt == ST_OPREADY) recover_flag_next = 1'b0;
      if (nxt == ST_ERROR)   recover_flag_next = 1'b1;
      if (recover_flag_next) begin
        if (nxt == ST_ERROR)           pending_request_next = ST_IDLE;
        else if (nxt == ST_IDLE)       pending_request_next = ST_CONFIGURED;
        else if (nxt == ST_CONFIGURED) pending_request_next = ST_OPREADY;
      end
    end else if (current_state != ST_FATAL) begin
      pending_request_next = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state   <= ST_S0;
      pending_request <= ST_NONE;
      status_reg      <= 4'd0;
      recover_flag    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        current_state   <= current_state_next;
        pending_request <= pending_request_next;
        status_reg      <= status_reg_next;
        recover_flag    <= recover_flag_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      state_now        <= current_state_next;
      status_now       <= status_reg_next;
      action_fired     <= action;
      clear_diag_pulse <= pulse;
      state_changed    <= changed;
    end
  end

endmodule

// ===== rtl/flsm_checker.sv =====
// port-level checks for the firmware lifecycle state machine, with bind
`include "firmware_lifecycle_state_machine_core_defines.svh"

module flsm_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [2:0]       func,
  input logic [1:0]       fault_request,
  input logic [3:0]       action_status,
  input logic [3:0]       init_status,
  input logic             out_valid,
  input logic             out_ready,
  input flsm_pkg::state_t state_now,
  input logic [3:0]       status_now,
  input flsm_pkg::act_t   action_fired,
  input logic             clear_diag_pulse,
  input logic             state_changed
);
  import flsm_pkg::*;

  logic   seen_fatal;
  logic   have_last;
  state_t last_state;
  logic   out_take;

  assign out_take = out_valid && out_ready;

  // track the last delivered state
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_fatal <= 1'b0;
      have_last  <= 1'b0;
    end else if (out_take) begin
      have_last <= 1'b1;
      if (state_now == ST_FATAL) seen_fatal <= 1'b1;
    end
    if (out_take) last_state <= state_now;
  end

  // fatal is absorbing and quiet
  `FLSM_ASSERT_NOW(a_fatal_absorbing, out_valid && seen_fatal, state_now == ST_FATAL && action_fired == ACT_NONE && !state_changed && !clear_diag_pulse)

  // no change flag means the same state as the word before
  `FLSM_ASSERT_NOW(a_unchanged_state, out_valid && have_last && !state_changed, state_now == last_state)

  // entering operation lands in opready or, on failure, in error
  `FLSM_ASSERT_NOW(a_enter_op_target, out_valid && action_fired == ACT_ENTER_OP, state_now == ST_OPREADY || state_now == ST_ERROR)

  // stalled result word holds
  `FLSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(state_now) && $stable(status_now) && $stable(state_changed))

endmodule

bind firmware_lifecycle_state_machine_core flsm_checker u_flsm_checker (.*);
